@@ sv/i2p_pkg.sv @@
// ----------------------------------------------------------------------------
// i2p_pkg: shared definitions for the infix to postfix converter
// Character codes, stack control codes and precedence helpers.
// ----------------------------------------------------------------------------
package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	typedef logic [7:0]       sym_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam sym_t CH_MUL   = 8'h2A;
	localparam sym_t CH_DIV   = 8'h2F;
	localparam sym_t CH_ADD   = 8'h2B;
	localparam sym_t CH_SUB   = 8'h2D;
	localparam sym_t CH_OPEN  = 8'h28;
	localparam sym_t CH_CLOSE = 8'h29;

	// Move applied to every stack cell together
	typedef enum logic [1:0] {
		STK_HOLD,
		STK_PUSH,
		STK_POP
	} stk_op_t;

	// Letters and digits pass straight through
	function automatic logic is_alnum(sym_t c);
		logic res;
		res = c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
		return res;
	endfunction

	// True when the stacked entry must leave before the incoming character
	function automatic logic pops_before(sym_t stacked, sym_t incoming);
		logic high;
		logic low;
		logic res;
		high = (stacked == CH_MUL) || (stacked == CH_DIV);
		low  = (stacked == CH_ADD) || (stacked == CH_SUB);
		case (incoming)
			CH_MUL, CH_DIV: res = high;
			CH_ADD, CH_SUB: res = high | low;
			CH_CLOSE:       res = (stacked != CH_OPEN);
			default:        res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

@@ sv/i2p_cell.sv @@
// ----------------------------------------------------------------------------
// i2p_cell: one entry of the shifting operator stack
// On a push the cell takes its upper neighbor, on a pop its lower neighbor.
// ----------------------------------------------------------------------------
module i2p_cell (
	input  logic              clk,
	input  i2p_pkg::stk_op_t  op,
	input  i2p_pkg::sym_t     above,  // entry nearer the top (or new symbol)
	input  i2p_pkg::sym_t     below,  // entry deeper in the stack
	output i2p_pkg::sym_t     data
);
	import i2p_pkg::*;

	sym_t data_q;

	// Shift with the rest of the row
	always_ff @(posedge clk) begin
		case (op)
			STK_PUSH: data_q <= above;
			STK_POP:  data_q <= below;
			default:  data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

@@ sv/infix_to_postfix_converter_top.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: shunting-yard infix to postfix converter
// An item is captured into cmd_q and sym_q, and each result is registered in the
// output register before m_tvalid rises. s_tready is high only while idle, so a new
// item is taken only once the last is done; one pop a cycle unless m_tready stalls.
// The operator stack is a row of shifting cells, top entry in cell 0.
// Reset clears the state, stack count, error flag and output valid; stack cells are not reset.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] symbol
	input  logic [0:0] s_tuser,   // [0] command
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_symbol
	output logic [2:0] m_tuser,   // [0] has_symbol, [1] expression_done, [2] error
	output logic       m_tlast    // last
);
	import i2p_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	state_t  state_q;
	logic    cmd_q;
	sym_t    sym_q;
	cnt_t    count_q;
	logic    error_q;
	logic    m_tvalid_q;
	sym_t    out_sym_q;
	logic    out_has_q;
	logic    out_last_q;
	logic    out_done_q;
	logic    out_err_q;

	sym_t    cell_data [STACK_DEPTH];
	stk_op_t stk_op;

	logic    can_emit;
	logic    emit;
	logic    finish;
	logic    set_err;
	sym_t    o_sym;
	logic    o_has;
	logic    o_last;
	logic    o_done;
	logic    o_err;

	// Row of stack cells, each fed by its neighbors
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		sym_t above;
		sym_t below;
		if (i == 0) begin : g_top
			assign above = sym_q;
		end else begin : g_mid
			assign above = cell_data[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign below = cell_data[i];
		end else begin : g_deep
			assign below = cell_data[i+1];
		end
		i2p_cell u_cell (
			.clk   (clk),
			.op    (stk_op),
			.above (above),
			.below (below),
			.data  (cell_data[i])
		);
	end

	assign can_emit = !m_tvalid_q || m_tready;

	// Decide the move of this cycle
	always_comb begin
		emit    = 1'b0;
		finish  = 1'b0;
		set_err = 1'b0;
		stk_op  = STK_HOLD;
		o_sym   = cell_data[0];
		o_has   = 1'b1;
		o_last  = 1'b0;
		o_done  = 1'b0;
		o_err   = 1'b0;
		if (state_q == ST_WORK) begin
			if (cmd_q) begin
				// Flush the stack in pop order
				o_done = 1'b1;
				o_err  = error_q;
				emit   = can_emit;
				if (count_q == '0) begin
					o_sym  = '0;
					o_has  = 1'b0;
					o_last = 1'b1;
					finish = can_emit;
				end else begin
					o_last = (count_q == CNT_W'(1));
					stk_op = can_emit ? STK_POP : STK_HOLD;
					finish = can_emit && o_last;
				end
			end else if (is_alnum(sym_q)) begin
				o_sym  = sym_q;
				o_last = 1'b1;
				emit   = can_emit;
				finish = can_emit;
			end else if (count_q != '0 && pops_before(cell_data[0], sym_q)) begin
				// Pop one entry of higher or equal precedence, or any non-open entry on a close parenthesis
				o_last = !(count_q > CNT_W'(1) && pops_before(cell_data[1], sym_q));
				emit   = can_emit;
				stk_op = can_emit ? STK_POP : STK_HOLD;
			end else begin
				// Push, discard the open parenthesis, or flag an error
				finish = 1'b1;
				if (sym_q == CH_CLOSE) begin
					if (count_q != '0) begin
						stk_op = STK_POP;
					end else begin
						set_err = 1'b1;
					end
				end else if (count_q != CNT_W'(STACK_DEPTH)) begin
					stk_op = STK_PUSH;
				end else begin
					set_err = 1'b1;
				end
			end
		end
	end

	// State, stack count, error flag and output valid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			error_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			case (stk_op)
				STK_PUSH: count_q <= count_q + CNT_W'(1);
				STK_POP:  count_q <= count_q - CNT_W'(1);
				default:  count_q <= count_q;
			endcase

			if (finish && cmd_q) begin
				error_q <= 1'b0;
			end else if (set_err) begin
				error_q <= 1'b1;
			end

			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Capture the item and the result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= s_tuser[0];
			sym_q <= s_tdata;
		end
		if (emit) begin
			out_sym_q  <= o_sym;
			out_has_q  <= o_has;
			out_last_q <= o_last;
			out_done_q <= o_done;
			out_err_q  <= o_err;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_sym_q;
	assign m_tuser  = {out_err_q, out_done_q, out_has_q};
	assign m_tlast  = out_last_q;

	// Stack count stays within the row of cells
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count above depth");

	// No pop from an empty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(stk_op == STK_POP) |-> (count_q != '0))
		else $error("pop on empty stack");

	// No push into a full stack
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(stk_op == STK_PUSH) |-> (count_q != CNT_W'(STACK_DEPTH)))
		else $error("push on full stack");

	// Final flush result leaves an empty stack and a clear error flag
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && o_done && o_last) |=> (count_q == '0 && !error_q))
		else $error("flush did not clear state");

	// Results are produced only while an item is at work
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (state_q == ST_WORK && can_emit))
		else $error("result outside of work");

endmodule

@@ tb/infix_to_postfix_converter_top_test.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_test: stream test of the postfix converter
// Sends infix characters and end commands through the slave stream. A
// scoreboard keeps its own operator stack and predicts every postfix item.
// Each item taken from the master stream is compared with the oldest
// prediction. Random gaps fall on both sides of the block.
// ----------------------------------------------------------------------------
import i2p_pkg::*;

// One predicted postfix item
typedef struct packed {
	sym_t sym;
	logic has;
	logic last;
	logic done;
	logic err;
} postfix_res_t;

// One infix item for the slave stream
typedef struct packed {
	logic cmd;
	sym_t sym;
} infix_item_t;

// Letters and digits only
function automatic bit is_letter_or_digit(sym_t c);
	return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
endfunction

class postfix_scoreboard;
	sym_t         op_stack[STACK_DEPTH];
	int           op_count;
	bit           err_flag;
	postfix_res_t postfix_q[$];
	int           mismatches;

	// Binding strength of an operator, zero for anything else
	function int rank(sym_t c);
		if (c == CH_MUL || c == CH_DIV) begin
			return 2;
		end
		if (c == CH_ADD || c == CH_SUB) begin
			return 1;
		end
		return 0;
	endfunction

	// True when the top entry leaves the stack ahead of the incoming character
	function bit leaves_first(sym_t top, sym_t incoming);
		if (incoming == CH_CLOSE) begin
			return top != CH_OPEN;
		end
		if (rank(incoming) == 0) begin
			return 0;
		end
		return rank(top) >= rank(incoming);
	endfunction

	function void add_postfix(sym_t sym, logic has, logic done, logic err);
		postfix_res_t r;
		r.sym  = sym;
		r.has  = has;
		r.last = 1'b0;
		r.done = done;
		r.err  = err;
		postfix_q.push_back(r);
	endfunction

	// Predict the postfix items that one accepted infix item causes
	function void note_item(logic cmd, sym_t c);
		int           before_n;
		postfix_res_t r;
		before_n = postfix_q.size();
		if (cmd) begin
			// Flush the stack, then clear the sticky error
			if (op_count == 0) begin
				add_postfix(8'h00, 1'b0, 1'b1, err_flag);
			end
			while (op_count > 0) begin
				op_count--;
				add_postfix(op_stack[op_count], 1'b1, 1'b1, err_flag);
			end
			err_flag = 1'b0;
		end else if (is_letter_or_digit(c)) begin
			add_postfix(c, 1'b1, 1'b0, 1'b0);
		end else begin
			// Pop what binds at least as tightly, then push or discard
			while (op_count > 0 && leaves_first(op_stack[op_count - 1], c)) begin
				op_count--;
				add_postfix(op_stack[op_count], 1'b1, 1'b0, 1'b0);
			end
			if (c == CH_CLOSE) begin
				if (op_count > 0) begin
					op_count--;
				end else begin
					err_flag = 1'b1;
				end
			end else if (op_count >= STACK_DEPTH) begin
				err_flag = 1'b1;
			end else begin
				op_stack[op_count] = c;
				op_count++;
			end
		end
		// Mark the final item of this step
		if (postfix_q.size() > before_n) begin
			r = postfix_q.pop_back();
			r.last = 1'b1;
			postfix_q.push_back(r);
		end
	endfunction

	task report(string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	// Compare one accepted postfix item with the oldest prediction
	task check_result(sym_t sym, logic has, logic last, logic done, logic err);
		postfix_res_t e;
		if (postfix_q.size() == 0) begin
			report($sformatf("unexpected item sym=%h has=%b last=%b done=%b err=%b",
				sym, has, last, done, err));
		end else begin
			e = postfix_q.pop_front();
			if (sym !== e.sym || has !== e.has || last !== e.last ||
					done !== e.done || err !== e.err) begin
				report($sformatf("got sym=%h has=%b last=%b done=%b err=%b, want %h %b %b %b %b",
					sym, has, last, done, err, e.sym, e.has, e.last, e.done, e.err));
			end
		end
	endtask

	function int pending();
		return postfix_q.size();
	endfunction
endclass

module infix_to_postfix_converter_top_test;

	localparam int RANDOM_ITEMS = 120;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] symbol
	logic [0:0] s_tuser = 1'b0;    // [0] command
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_symbol
	logic [2:0] m_tuser;           // [0] has_symbol, [1] expression_done, [2] error
	logic       m_tlast;

	postfix_scoreboard sb;
	infix_item_t       infix_q[$];
	int                cycles = 0;

	infix_to_postfix_converter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, a few long, none while calm
	function automatic int pick_gap(bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_char(sym_t c);
		infix_item_t it;
		it.cmd = 1'b0;
		it.sym = c;
		infix_q.push_back(it);
	endfunction

	// The symbol is ignored on an end command, so give it random bits
	function automatic void add_end();
		infix_item_t it;
		it.cmd = 1'b1;
		it.sym = sym_t'($urandom_range(0, 255));
		infix_q.push_back(it);
	endfunction

	function automatic sym_t pick_operand();
		int idx;
		idx = $urandom_range(0, 61);
		if (idx < 10) begin
			return sym_t'("0" + idx);
		end
		if (idx < 36) begin
			return sym_t'("A" + idx - 10);
		end
		return sym_t'("a" + idx - 36);
	endfunction

	function automatic sym_t pick_operator();
		case ($urandom_range(0, 3))
			0: return CH_MUL;
			1: return CH_DIV;
			2: return CH_ADD;
			default: return CH_SUB;
		endcase
	endfunction

	// A character that is neither alphanumeric, an operator nor a parenthesis
	function automatic sym_t pick_other();
		sym_t c;
		do begin
			c = sym_t'($urandom_range(0, 255));
		end while (is_letter_or_digit(c) || c == CH_MUL || c == CH_DIV || c == CH_ADD ||
			c == CH_SUB || c == CH_OPEN || c == CH_CLOSE);
		return c;
	endfunction

	// Well-formed expression with random operands, operators and nesting
	function automatic void add_expression();
		int terms;
		int depth;
		terms = $urandom_range(1, 7);
		depth = 0;
		for (int i = 0; i < terms; i++) begin
			while (depth < 5 && $urandom_range(0, 3) == 0) begin
				add_char(CH_OPEN);
				depth++;
			end
			add_char(pick_operand());
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				add_char(CH_CLOSE);
				depth--;
			end
			if (i < terms - 1) begin
				add_char(pick_operator());
			end
		end
		while (depth > 0) begin
			add_char(CH_CLOSE);
			depth--;
		end
		add_end();
	endfunction

	// Random mix of parentheses, operators and operands, end not always sent
	function automatic void add_broken();
		int n;
		n = $urandom_range(2, 10);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: add_char(CH_OPEN);
				1: add_char(CH_CLOSE);
				2: add_char(pick_operator());
				default: add_char(pick_operand());
			endcase
		end
		if ($urandom_range(0, 3) != 0) begin
			add_end();
		end
	endfunction

	// Arbitrary bytes and commands
	function automatic void add_noise();
		int          n;
		infix_item_t it;
		n = $urandom_range(1, 6);
		repeat (n) begin
			it.cmd = ($urandom_range(0, 7) == 0);
			it.sym = sym_t'($urandom_range(0, 255));
			infix_q.push_back(it);
		end
	endfunction

	// Fill the stack with entries that never pop, then flush
	function automatic void add_deep(int n);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0) begin
				add_char(CH_OPEN);
			end else begin
				add_char(pick_other());
			end
		end
		add_end();
	endfunction

	function automatic void build_directed();
		// Alphanumeric range ends
		add_char("0");
		add_char("9");
		add_char("A");
		add_char("Z");
		add_char("a");
		add_char("z");
		// Precedence chain: each operator after the first pops the one before it
		add_char(CH_MUL);
		add_char(CH_DIV);
		add_char(CH_ADD);
		add_char(CH_SUB);
		add_char(CH_OPEN);
		add_char("#");
		add_char(CH_CLOSE);
		// Close with no open left: unmatched, sets the error
		add_char(CH_CLOSE);
		// Other characters push without popping, then flush with error
		add_char(8'h00);
		add_char(8'hFF);
		add_end();
		// Empty flush
		add_end();
		// Unmatched open flushes like any entry
		add_char(CH_OPEN);
		add_end();
		// Neighbors of the alphanumeric ranges
		add_char(":");
		add_char("@");
		add_char("[");
		add_char("{");
		add_end();
	endfunction

	function automatic void build_random();
		int target;
		target = infix_q.size() + RANDOM_ITEMS;
		add_deep($urandom_range(33, 38));
		while (infix_q.size() < target) begin
			case ($urandom_range(0, 19))
				0: add_deep($urandom_range(20, 40));
				1, 2, 3, 4: add_broken();
				5, 6, 7: add_noise();
				default: add_expression();
			endcase
		end
		add_end();
	endfunction

	// Present one item after a random gap and hold until accepted
	task automatic send_item(infix_item_t it, bit calm);
		int gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it.sym;
		s_tuser  <= it.cmd;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Sample both handshakes at the edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			sb.note_item(s_tuser[0], s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2]);
		end
	end

	// Stall the master side at random
	initial begin
		bit calm;
		int stall;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				calm = ~calm;
			end
			stall = pick_gap(calm);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		bit calm;
		sb = new();
		calm = 1'b0;
		build_directed();
		build_random();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Drive every item, switching calm stretches now and then
		foreach (infix_q[i]) begin
			if ($urandom_range(0, 29) == 0) begin
				calm = ~calm;
			end
			send_item(infix_q[i], calm);
		end
		s_tvalid <= 1'b0;
		// Let the last accepted item reach the scoreboard before draining
		@(posedge clk);
		// Drain, then let any silent item finish
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.report($sformatf("%0d predicted items never arrived", sb.pending()));
		end
		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
